/* rtl/evtmr_pkg.sv */
`timescale 1ns / 1ps

package evtmr_pkg;

    // Field and bus widths
    localparam int DATA_W     = 64;
    localparam int ADDR_W     = 7;
    localparam int CMD_W      = 2;
    localparam int IRQ_W      = 3;
    localparam int PERIOD_W   = 27;
    localparam int VENDOR_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 72;
    localparam int M_PAD_W    = M_TDATA_W - DATA_W - IRQ_W;

    // Timer count; word index of a timer inside the timer area
    localparam int NUM_TIMERS = 3;
    localparam int TIDX_W     = ADDR_W - 2;

    // Reset values of the configuration registers
    localparam logic [PERIOD_W-1:0] TICK_PERIOD_RST = PERIOD_W'(69841279);
    localparam logic [VENDOR_W-1:0] VENDOR_RST      = '0;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFGR_TICK_PERIOD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFGR_VENDOR      = CFG_IDX_W'(1);

    // Word map
    localparam logic [ADDR_W-1:0] ADDR_CAP        = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] ADDR_GCFG       = ADDR_W'(2);
    localparam logic [ADDR_W-1:0] ADDR_ISR        = ADDR_W'(4);
    localparam logic [ADDR_W-1:0] ADDR_COUNT      = ADDR_W'(30);
    localparam logic [ADDR_W-1:0] ADDR_TIMER_BASE = ADDR_W'(32);

    // Word offsets inside one timer's block of four words
    localparam logic [1:0] SUB_CFG = 2'd0;
    localparam logic [1:0] SUB_CMP = 2'd1;

    // Global config bits
    localparam int GB_ENABLE = 0;

    // Capability constants
    localparam logic [7:0] REV_ID = 8'h01;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    // Stored timer config bits (word bits 6, 3, 2, 1)
    typedef struct packed {
        logic valset;
        logic periodic;
        logic enable;
        logic level;
    } tmr_cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] word_addr;
        logic [DATA_W-1:0] write_data;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [IRQ_W-1:0]  irq_lines;
        logic              bad_access;
    } result_t;

    // Build the config word as read back by software
    function automatic logic [DATA_W-1:0] tmr_cfg_word(input tmr_cfg_t c);
        logic [DATA_W-1:0] w;
        w    = '0;
        w[1] = c.level;
        w[2] = c.enable;
        w[3] = c.periodic;
        w[4] = 1'b1;
        w[5] = 1'b1;
        w[6] = c.valset;
        return w;
    endfunction

    // Extract stored config bits from a written word
    function automatic tmr_cfg_t tmr_cfg_from(input logic [DATA_W-1:0] w);
        tmr_cfg_t c;
        c.level    = w[1];
        c.enable   = w[2];
        c.periodic = w[3];
        c.valset   = w[6];
        return c;
    endfunction

endpackage

/* rtl/event_timer_device_unit.sv */
`timescale 1ns / 1ps

// Event timer with the HPET register layout: 64-bit main counter, three comparator
// timers and a write-1-to-clear level status register. Each input transaction is a
// 64-bit bus read, a bus write, one counter tick or a no-op (tuser), and each gives
// exactly one result transaction with read data, the three interrupt lines after the
// item and an unmapped-access flag. One transaction is taken per clock while the
// result is not stalled. The accepting edge loads the input register, and the state
// update (counter increment and comparator match) runs into the result register on
// an edge where that register is free or draining. A stalled result holds the item
// in the input register and stalls the input behind it. Configuration writes (tick
// period, vendor code) are taken at any time and should be made only while no
// transaction is in flight.
module event_timer_device_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [evtmr_pkg::S_TDATA_W-1:0]  s_tdata,   // word_addr, write_data, pad
    input  logic [evtmr_pkg::CMD_W-1:0]      s_tuser,   // cmd
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [evtmr_pkg::M_TDATA_W-1:0]  m_tdata,   // read_data, irq_lines, pad
    output logic                             m_tuser,   // bad_access
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [evtmr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [evtmr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import evtmr_pkg::*;

    logic                tick_period_reg_en;
    logic [PERIOD_W-1:0] tick_period_reg;
    logic [VENDOR_W-1:0] vendor_reg;
    logic                item_valid;
    item_t               item;
    logic                fire;
    result_t             result;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg;

    // Configuration write channel
    assign cfg_ready          = 1'b1;
    assign tick_period_reg_en = cfg_valid && cfg_ready && (cfg_index == CFGR_TICK_PERIOD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_period_reg <= TICK_PERIOD_RST;
            vendor_reg      <= VENDOR_RST;
        end else begin
            if (tick_period_reg_en) begin
                tick_period_reg <= cfg_data[PERIOD_W-1:0];
            end
            if (cfg_valid && cfg_ready && (cfg_index == CFGR_VENDOR)) begin
                vendor_reg <= cfg_data[VENDOR_W-1:0];
            end
        end
    end

    // Advance the held item when the result register is free or draining
    assign fire = item_valid && (!out_valid_reg || m_tready);

    evtmr_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    evtmr_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .item        (item),
        .tick_period (tick_period_reg),
        .vendor      (vendor_reg),
        .result      (result)
    );

    // Result register
    assign out_valid_next = fire ? 1'b1 : ((out_valid_reg && !m_tready) ? 1'b1 : 1'b0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {M_PAD_W'(0), out_reg.irq_lines, out_reg.read_data};
    assign m_tuser  = out_reg.bad_access;

`ifndef SYNTHESIS
    // An unmapped access always returns zero data
    a_bad_reads_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[DATA_W-1:0] == '0))
        else $error("unmapped access returned nonzero data");

    // Input stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    // A write produces zero read data
    a_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (item.cmd == CMD_WRITE) |=> (m_tdata[DATA_W-1:0] == '0))
        else $error("write returned nonzero data");
`endif

endmodule

/* rtl/evtmr_in_stage.sv */
`timescale 1ns / 1ps

module evtmr_in_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [evtmr_pkg::S_TDATA_W-1:0] s_tdata,  // word_addr, write_data, pad
    input  logic [evtmr_pkg::CMD_W-1:0]     s_tuser,  // cmd
    input  logic                            advance,
    output logic                            item_valid,
    output evtmr_pkg::item_t                item
);
    import evtmr_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    // Take a new transaction when empty or when the held one moves on
    assign s_tready   = !valid_reg || advance;
    assign load       = s_tvalid && s_tready;
    assign valid_next = load ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Unpack the payload into the item register
    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg.cmd        <= s_tuser;
            item_reg.word_addr  <= s_tdata[ADDR_W-1:0];
            item_reg.write_data <= s_tdata[ADDR_W +: DATA_W];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* rtl/evtmr_core.sv */
`timescale 1ns / 1ps

module evtmr_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           fire,
    input  evtmr_pkg::item_t               item,
    input  logic [evtmr_pkg::PERIOD_W-1:0] tick_period,
    input  logic [evtmr_pkg::VENDOR_W-1:0] vendor,
    output evtmr_pkg::result_t             result
);
    import evtmr_pkg::*;

    logic [DATA_W-1:0]     count_reg,  count_next;
    logic [1:0]            gbits_reg,  gbits_next;
    logic [NUM_TIMERS-1:0] status_reg, status_next;
    tmr_cfg_t              tcfg_reg [NUM_TIMERS];
    tmr_cfg_t              tcfg_next[NUM_TIMERS];
    logic [DATA_W-1:0]     cmp_reg  [NUM_TIMERS];
    logic [DATA_W-1:0]     cmp_next [NUM_TIMERS];
    logic [DATA_W-1:0]     per_reg  [NUM_TIMERS];
    logic [DATA_W-1:0]     per_next [NUM_TIMERS];

    logic [DATA_W-1:0]     count_inc;
    logic [DATA_W-1:0]     cap_word;
    logic                  in_timer;
    logic [ADDR_W-1:0]     rel_addr;
    logic [TIDX_W-1:0]     tidx;
    logic [1:0]            sub;
    logic [NUM_TIMERS-1:0] tsel;
    logic [DATA_W-1:0]     rd_cfg;
    logic [DATA_W-1:0]     rd_cmp;
    logic [NUM_TIMERS-1:0] pulse;
    logic [DATA_W-1:0]     rd;
    logic                  bad;
    logic                  is_wr;

    assign count_inc = count_reg + DATA_W'(1);

    // Capability word: period, vendor, legacy capable, 64-bit counter, timer count, rev
    assign cap_word = {(DATA_W - 32 - PERIOD_W)'(0), tick_period, vendor,
                       1'b1, 1'b0, 1'b1, 5'(NUM_TIMERS - 1), REV_ID};

    // Decode the timer area and select the addressed timer
    assign in_timer = item.word_addr >= ADDR_TIMER_BASE;
    assign rel_addr = item.word_addr - ADDR_TIMER_BASE;
    assign tidx     = rel_addr[ADDR_W-1:2];
    assign sub      = rel_addr[1:0];

    always_comb begin
        rd_cfg = '0;
        rd_cmp = '0;
        for (int n = 0; n < NUM_TIMERS; n++) begin
            tsel[n] = in_timer && (tidx == TIDX_W'(n));
            if (tsel[n]) begin
                rd_cfg = rd_cfg | tmr_cfg_word(tcfg_reg[n]);
                rd_cmp = rd_cmp | cmp_reg[n];
            end
        end
    end

    // Apply one item to the register state
    always_comb begin
        count_next  = count_reg;
        gbits_next  = gbits_reg;
        status_next = status_reg;
        for (int n = 0; n < NUM_TIMERS; n++) begin
            tcfg_next[n] = tcfg_reg[n];
            cmp_next[n]  = cmp_reg[n];
            per_next[n]  = per_reg[n];
        end
        pulse = '0;
        rd    = '0;
        bad   = 1'b0;
        is_wr = item.cmd == CMD_WRITE;

        case (item.cmd)
            CMD_TICK: begin
                if (gbits_reg[GB_ENABLE]) begin
                    count_next = count_inc;
                    for (int n = 0; n < NUM_TIMERS; n++) begin
                        if (tcfg_reg[n].enable && (count_inc == cmp_reg[n])) begin
                            if (tcfg_reg[n].level) begin
                                status_next[n] = 1'b1;
                            end else begin
                                pulse[n] = 1'b1;
                            end
                            if (tcfg_reg[n].periodic) begin
                                cmp_next[n] = cmp_reg[n] + per_reg[n];
                            end
                        end
                    end
                end
            end
            CMD_READ, CMD_WRITE: begin
                case (item.word_addr)
                    ADDR_CAP: begin
                        rd = cap_word;
                    end
                    ADDR_GCFG: begin
                        if (is_wr) begin
                            gbits_next = item.write_data[1:0];
                        end
                        rd = DATA_W'(gbits_reg);
                    end
                    ADDR_ISR: begin
                        if (is_wr) begin
                            status_next = status_reg & ~item.write_data[NUM_TIMERS-1:0];
                        end
                        rd = DATA_W'(status_reg);
                    end
                    ADDR_COUNT: begin
                        if (is_wr) begin
                            count_next = item.write_data;
                        end
                        rd = count_reg;
                    end
                    default: begin
                        if ((|tsel) && (sub == SUB_CFG)) begin
                            for (int n = 0; n < NUM_TIMERS; n++) begin
                                if (is_wr && tsel[n]) begin
                                    tcfg_next[n] = tmr_cfg_from(item.write_data);
                                end
                            end
                            rd = rd_cfg;
                        end else if ((|tsel) && (sub == SUB_CMP)) begin
                            // Load comparator only when one-shot or VAL_SET; period always
                            for (int n = 0; n < NUM_TIMERS; n++) begin
                                if (is_wr && tsel[n]) begin
                                    if (!tcfg_reg[n].periodic || tcfg_reg[n].valset) begin
                                        cmp_next[n] = item.write_data;
                                    end
                                    per_next[n]         = item.write_data;
                                    tcfg_next[n].valset = 1'b0;
                                end
                            end
                            rd = rd_cmp;
                        end else begin
                            bad = 1'b1;
                            rd  = '0;
                        end
                    end
                endcase
                if (is_wr) begin
                    rd = '0;
                end
            end
            default: ;
        endcase
    end

    // Lines after the item: enabled level timers with status set, plus edge pulses
    always_comb begin
        for (int n = 0; n < IRQ_W; n++) begin
            result.irq_lines[n] = (tcfg_next[n].level && tcfg_next[n].enable &&
                                   status_next[n]) || pulse[n];
        end
        result.read_data  = rd;
        result.bad_access = bad;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            gbits_reg  <= '0;
            status_reg <= '0;
            for (int n = 0; n < NUM_TIMERS; n++) begin
                tcfg_reg[n] <= '0;
                cmp_reg[n]  <= '1;
                per_reg[n]  <= '0;
            end
        end else if (fire) begin
            count_reg  <= count_next;
            gbits_reg  <= gbits_next;
            status_reg <= status_next;
            for (int n = 0; n < NUM_TIMERS; n++) begin
                tcfg_reg[n] <= tcfg_next[n];
                cmp_reg[n]  <= cmp_next[n];
                per_reg[n]  <= per_next[n];
            end
        end
    end

endmodule

/* tb/event_timer_device_unit_tb.sv */
`timescale 1ns / 1ps

module event_timer_device_unit_tb;
    import evtmr_pkg::*;

    // Timer config word bit positions
    localparam int CFGB_LEVEL    = 1;
    localparam int CFGB_ENABLE   = 2;
    localparam int CFGB_PERIODIC = 3;
    localparam int CFGB_VALSET   = 6;

    // Command code that the block treats as a no-op
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    // Receiver hold-off: start after this many results; load value of the hold-off counter
    localparam int HOLD_AT     = 600;
    localparam int HOLD_CYCLES = 300;

    localparam int PHASE_ITEMS = 230;

    // Tracks the timer state and queues the response each bus transaction should give
    class timer_scoreboard;
        logic [DATA_W-1:0]   ctr;
        logic [1:0]          glb;
        logic [IRQ_W-1:0]    sts;
        tmr_cfg_t            tcfg [NUM_TIMERS];
        logic [DATA_W-1:0]   tcmp [NUM_TIMERS];
        logic [DATA_W-1:0]   tper [NUM_TIMERS];
        logic [PERIOD_W-1:0] period_fs;
        logic [VENDOR_W-1:0] vendor_id;
        result_t             pending_results [$];
        int                  errors;

        function new();
            int n;
            errors    = 0;
            ctr       = '0;
            glb       = '0;
            sts       = '0;
            period_fs = TICK_PERIOD_RST;
            vendor_id = VENDOR_RST;
            for (n = 0; n < NUM_TIMERS; n++) begin
                tcfg[n] = '0;
                tcmp[n] = '1;
                tper[n] = '0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFGR_TICK_PERIOD) begin
                period_fs = val[PERIOD_W-1:0];
            end else if (idx == CFGR_VENDOR) begin
                vendor_id = val[VENDOR_W-1:0];
            end
        endfunction

        // Apply one accepted transaction and queue the response it gives
        function void predict_access(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                                     logic [DATA_W-1:0] data);
            result_t          r;
            logic [IRQ_W-1:0] pulse;
            logic [ADDR_W-1:0] rel;
            logic [1:0]       sub;
            logic             mapped;
            logic             is_wr;
            int               t;
            int               n;
            r      = '0;
            pulse  = '0;
            mapped = 1'b1;
            is_wr  = (cmd == CMD_WRITE);
            if (cmd == CMD_TICK) begin
                // Advance the counter and fire matching timers
                if (glb[GB_ENABLE]) begin
                    ctr = ctr + 1'b1;
                    for (n = 0; n < NUM_TIMERS; n++) begin
                        if (tcfg[n].enable && ctr == tcmp[n]) begin
                            if (tcfg[n].level) sts[n] = 1'b1;
                            else pulse[n] = 1'b1;
                            if (tcfg[n].periodic) tcmp[n] = tcmp[n] + tper[n];
                        end
                    end
                end
            end else if (cmd == CMD_READ || cmd == CMD_WRITE) begin
                if (addr == ADDR_CAP) begin
                    // Capabilities: writes are dropped silently
                    r.read_data[7:0]   = REV_ID;
                    r.read_data[12:8]  = 5'(NUM_TIMERS - 1);
                    r.read_data[13]    = 1'b1;
                    r.read_data[15]    = 1'b1;
                    r.read_data[31:16] = vendor_id;
                    r.read_data[63:32] = 32'(period_fs);
                end else if (addr == ADDR_GCFG) begin
                    if (is_wr) glb = data[1:0];
                    else r.read_data = 64'(glb);
                end else if (addr == ADDR_ISR) begin
                    if (is_wr) sts = sts & ~data[IRQ_W-1:0];
                    else r.read_data = 64'(sts);
                end else if (addr == ADDR_COUNT) begin
                    if (is_wr) ctr = data;
                    else r.read_data = ctr;
                end else if (addr >= ADDR_TIMER_BASE) begin
                    rel = addr - ADDR_TIMER_BASE;
                    t   = int'(rel >> 2);
                    sub = rel[1:0];
                    if (t < NUM_TIMERS && sub == SUB_CFG) begin
                        if (is_wr) begin
                            tcfg[t].level    = data[CFGB_LEVEL];
                            tcfg[t].enable   = data[CFGB_ENABLE];
                            tcfg[t].periodic = data[CFGB_PERIODIC];
                            tcfg[t].valset   = data[CFGB_VALSET];
                        end else begin
                            r.read_data[CFGB_LEVEL]    = tcfg[t].level;
                            r.read_data[CFGB_ENABLE]   = tcfg[t].enable;
                            r.read_data[CFGB_PERIODIC] = tcfg[t].periodic;
                            r.read_data[5:4]           = 2'b11;
                            r.read_data[CFGB_VALSET]   = tcfg[t].valset;
                        end
                    end else if (t < NUM_TIMERS && sub == SUB_CMP) begin
                        // One-shot or VAL_SET loads the comparator; period always loads
                        if (is_wr) begin
                            if (!tcfg[t].periodic || tcfg[t].valset) tcmp[t] = data;
                            tper[t]        = data;
                            tcfg[t].valset = 1'b0;
                        end else begin
                            r.read_data = tcmp[t];
                        end
                    end else begin
                        mapped = 1'b0;
                    end
                end else begin
                    mapped = 1'b0;
                end
                if (!mapped) begin
                    r.read_data  = '0;
                    r.bad_access = 1'b1;
                end
                if (is_wr) r.read_data = '0;
            end
            // Level lines follow status; edge lines carry this tick's pulse
            for (n = 0; n < NUM_TIMERS; n++) begin
                r.irq_lines[n] = (tcfg[n].level && tcfg[n].enable && sts[n]) | pulse[n];
            end
            pending_results.push_back(r);
        endfunction

        // Compare one response with the oldest queued one
        function void check_response(logic [M_TDATA_W-1:0] tdata, logic tuser);
            result_t want;
            result_t got;
            got.read_data  = tdata[DATA_W-1:0];
            got.irq_lines  = tdata[DATA_W +: IRQ_W];
            got.bad_access = tuser;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected response read_data=%h irq_lines=%b bad_access=%b",
                         $time, got.read_data, got.irq_lines, got.bad_access);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.read_data !== want.read_data) begin
                $display("%0t: read_data expected %h actual %h",
                         $time, want.read_data, got.read_data);
                errors++;
            end
            if (got.irq_lines !== want.irq_lines) begin
                $display("%0t: irq_lines expected %b actual %b",
                         $time, want.irq_lines, got.irq_lines);
                errors++;
            end
            if (got.bad_access !== want.bad_access) begin
                $display("%0t: bad_access expected %b actual %b",
                         $time, want.bad_access, got.bad_access);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [CMD_W-1:0]       s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    timer_scoreboard sb;
    int              src_idle_pct;
    int              dst_idle_pct;
    int              responses_seen;
    int              hold_left;
    bit              hold_done;

    event_timer_device_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Bound the run
    initial begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] timer_word(int n, logic [1:0] sub);
        return ADDR_TIMER_BASE + ADDR_W'(4 * n) + ADDR_W'(sub);
    endfunction

    // Offer one transaction, with a random gap first, and hold it until taken
    task automatic send_access(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                               logic [DATA_W-1:0] data);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_TDATA_W - DATA_W - ADDR_W){1'b0}}, data, addr};
        do @(posedge aclk); while (!s_tready);
        sb.predict_access(cmd, addr, data);
    endtask

    // Stop offering and wait until every queued response has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Pick a random transaction: ticks, reads, writes with timer programming near the live count, unmapped or no-op
    task automatic pick_access(output logic [CMD_W-1:0] cmd, output logic [ADDR_W-1:0] addr,
                               output logic [DATA_W-1:0] data);
        int sel;
        int pick;
        int tsel;
        data = {$urandom, $urandom};
        addr = ADDR_W'($urandom_range(0, 127));
        sel  = $urandom_range(0, 99);
        tsel = $urandom_range(0, NUM_TIMERS - 1);
        pick = $urandom_range(0, 9);
        if (sel < 40) begin
            cmd = CMD_TICK;
        end else if (sel < 58) begin
            cmd = CMD_READ;
            case (pick % 6)
                0: addr = ADDR_CAP;
                1: addr = ADDR_GCFG;
                2: addr = ADDR_ISR;
                3: addr = ADDR_COUNT;
                4: addr = timer_word(tsel, SUB_CFG);
                default: addr = timer_word(tsel, SUB_CMP);
            endcase
        end else if (sel < 90) begin
            cmd = CMD_WRITE;
            case (pick)
                0: begin
                    addr = ADDR_GCFG;
                    data[GB_ENABLE] = ($urandom_range(0, 7) != 0);
                end
                1: addr = ADDR_ISR;
                2: begin
                    addr = ADDR_COUNT;
                    if ($urandom_range(0, 1) == 0) data = '1 - 64'($urandom_range(0, 4));
                end
                3, 4: begin
                    addr = timer_word(tsel, SUB_CFG);
                    data[CFGB_ENABLE] = ($urandom_range(0, 3) != 0);
                end
                9: addr = timer_word(tsel, SUB_CMP);
                default: begin
                    addr = timer_word(tsel, SUB_CMP);
                    if ($urandom_range(0, 2) == 0) data = 64'($urandom_range(1, 12));
                    else data = sb.ctr + 64'($urandom_range(1, 12));
                end
            endcase
        end else if (sel < 96) begin
            cmd = ($urandom_range(0, 1) == 0) ? CMD_READ : CMD_WRITE;
        end else begin
            cmd = CMD_NOP;
        end
    endtask

    task automatic run_phase(int src_pct, int dst_pct, int n_items, bit pause_mid);
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        int                i;
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        for (i = 0; i < n_items; i++) begin
            if (pause_mid && i == n_items / 2) drain();
            pick_access(cmd, addr, data);
            send_access(cmd, addr, data);
        end
    endtask

    // Response side: check each transaction and drive ready
    initial begin
        m_tready       = 1'b0;
        responses_seen = 0;
        hold_left      = 0;
        hold_done      = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                sb.check_response(m_tdata, m_tuser);
                responses_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (responses_seen >= HOLD_AT && !hold_done) begin
                // Long hold-off so the block backs up and stalls its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
            end
        end
    end

    initial begin
        sb           = new();
        src_idle_pct = 0;
        dst_idle_pct = 0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = CMD_READ;
        cfg_valid    = 1'b0;
        cfg_index    = CFGR_TICK_PERIOD;
        cfg_data     = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: map edges, unmapped words, no-op, wrap, level/edge/periodic fires
        send_access(CMD_READ,  ADDR_CAP, '0);
        send_access(CMD_WRITE, ADDR_CAP, '1);
        send_access(CMD_READ,  ADDR_GCFG, '0);
        send_access(CMD_TICK,  ADDR_W'(127), '1);
        send_access(CMD_NOP,   ADDR_GCFG, '1);
        send_access(CMD_READ,  ADDR_W'(1), '0);
        send_access(CMD_WRITE, ADDR_W'(127), '1);
        send_access(CMD_READ,  timer_word(0, 2'd3), '0);
        send_access(CMD_READ,  timer_word(NUM_TIMERS, SUB_CFG), '0);
        send_access(CMD_WRITE, ADDR_COUNT, 64'hFFFF_FFFF_FFFF_FFFE);
        send_access(CMD_WRITE, timer_word(0, SUB_CFG), 64'h6);
        send_access(CMD_WRITE, timer_word(1, SUB_CFG), 64'h4);
        send_access(CMD_WRITE, timer_word(1, SUB_CMP), '1);
        send_access(CMD_WRITE, timer_word(2, SUB_CFG), 64'h4E);
        send_access(CMD_WRITE, timer_word(2, SUB_CMP), '1);
        send_access(CMD_READ,  timer_word(2, SUB_CFG), '0);
        send_access(CMD_WRITE, timer_word(2, SUB_CMP), 64'd2);
        send_access(CMD_WRITE, ADDR_GCFG, 64'h3);
        send_access(CMD_TICK,  '0, '0);
        send_access(CMD_TICK,  '0, '0);
        send_access(CMD_TICK,  '0, '0);
        send_access(CMD_READ,  ADDR_ISR, '0);
        send_access(CMD_WRITE, timer_word(0, SUB_CFG), 64'h4);
        send_access(CMD_WRITE, ADDR_ISR, '1);
        send_access(CMD_READ,  ADDR_COUNT, '0);
        send_access(CMD_WRITE, ADDR_COUNT, '0);
        send_access(CMD_READ,  timer_word(2, SUB_CMP), '0);
        drain();

        // Random phases, registers changed only while idle
        write_reg(CFGR_TICK_PERIOD, 32'd1);
        write_reg(CFGR_VENDOR, 32'hFFFF);
        run_phase(25, 75, PHASE_ITEMS, 1'b0);
        drain();
        write_reg(CFGR_TICK_PERIOD, 32'd100000000);
        write_reg(CFGR_VENDOR, 32'h0);
        run_phase(75, 25, PHASE_ITEMS, 1'b1);
        drain();
        write_reg(CFGR_TICK_PERIOD, 32'($urandom_range(1, 100000000)));
        write_reg(CFGR_VENDOR, 32'($urandom_range(0, 65535)));
        run_phase(0, 0, PHASE_ITEMS, 1'b0);
        drain();
        repeat (8) @(posedge aclk);

        if (sb.pending_results.size() != 0) begin
            $display("%0t: %0d responses never arrived", $time, sb.pending_results.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* event_timer_device_unit.f */
rtl/evtmr_pkg.sv
rtl/evtmr_in_stage.sv
rtl/evtmr_core.sv
rtl/event_timer_device_unit.sv
tb/event_timer_device_unit_tb.sv
